// ----- design/tlvtp_pkg.sv -----
`default_nettype none

package tlvtp_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_DEVICE_CODE      = 2'd0;
   localparam logic [1:0] CSR_TEMPERATURE_CODE = 2'd1;
   localparam logic [1:0] CSR_HUMIDITY_CODE    = 2'd2;

   // Reset values of the type codes
   localparam logic [7:0] DEVICE_CODE_RESET      = 8'd1;
   localparam logic [7:0] TEMPERATURE_CODE_RESET = 8'd2;
   localparam logic [7:0] HUMIDITY_CODE_RESET    = 8'd3;

   // Value length required of a known entry
   localparam logic [7:0] KNOWN_LENGTH = 8'd4;

   // Input command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Parser phase
   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_KNOWN = 2'd2,
      PH_SKIP  = 2'd3
   } phase_type;

endpackage

`default_nettype wire

// ----- design/tlv_telemetry_parser.sv -----
`default_nettype none

// TLV telemetry parser, one buffer byte per transaction.
// A result appears on rsp_ in the cycle after its end transaction is accepted.
// Throughput: one transaction per cycle; req_ready drops only while a result is stalled.
// The parser state updates in the accept cycle, so back-to-back bytes chain freely.
// Reset (synchronous, active high) restores type codes 1, 2, 3 and clears all parse state.
module tlv_telemetry_parser
   import tlvtp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_data_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic [31:0]      rsp_unit_ident,
   output logic [31:0]      rsp_temperature_bits,
   output logic [31:0]      rsp_humidity_bits,

   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);

   // Configuration registers
   logic [7:0] dev_code_ff, dev_code_in;
   logic [7:0] temp_code_ff, temp_code_in;
   logic [7:0] hum_code_ff, hum_code_in;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic [7:0]  entry_type_ff, entry_type_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] held_dev_ff, held_dev_in;
   logic [31:0] held_temp_ff, held_temp_in;
   logic [31:0] held_hum_ff, held_hum_in;
   logic        error_ff, error_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_dev_ff, rsp_dev_in;
   logic [31:0] rsp_temp_ff, rsp_temp_in;
   logic [31:0] rsp_hum_ff, rsp_hum_in;

   logic accept;
   logic entry_known;
   logic [7:0] bytes_dec;

   // Take a new transaction unless a finished result is stalled
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign entry_known = (entry_type_ff == dev_code_ff) || (entry_type_ff == temp_code_ff)
                        || (entry_type_ff == hum_code_ff);
   assign bytes_dec   = bytes_left_ff - 8'd1;

   // Configuration writes; indexes beyond the list are dropped
   always_comb begin
      dev_code_in  = dev_code_ff;
      temp_code_in = temp_code_ff;
      hum_code_in  = hum_code_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEVICE_CODE:      dev_code_in  = csr_write_data;
            CSR_TEMPERATURE_CODE: temp_code_in = csr_write_data;
            CSR_HUMIDITY_CODE:    hum_code_in  = csr_write_data;
            default:              ;
         endcase
      end
   end

   // Advance the parser and load the result on an end transaction
   always_comb begin
      phase_in      = phase_ff;
      entry_type_in = entry_type_ff;
      bytes_left_in = bytes_left_ff;
      value_in      = value_ff;
      held_dev_in   = held_dev_ff;
      held_temp_in  = held_temp_ff;
      held_hum_in   = held_hum_ff;
      error_in      = error_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dev_in    = rsp_dev_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_hum_in    = rsp_hum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (accept && req_cmd == CMD_END) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = error_ff || (phase_ff != PH_TYPE);
         rsp_dev_in    = held_dev_ff;
         rsp_temp_in   = held_temp_ff;
         rsp_hum_in    = held_hum_ff;
         // Clear everything but the type codes for the next buffer
         phase_in      = PH_TYPE;
         entry_type_in = '0;
         bytes_left_in = '0;
         value_in      = '0;
         held_dev_in   = '0;
         held_temp_in  = '0;
         held_hum_in   = '0;
         error_in      = 1'b0;
      end else if (accept && !error_ff) begin
         case (phase_ff)
            PH_LEN: begin
               bytes_left_in = req_data_byte;
               value_in      = '0;
               if (entry_known) begin
                  if (req_data_byte != KNOWN_LENGTH) begin
                     error_in = 1'b1;
                  end else begin
                     phase_in = PH_KNOWN;
                  end
               end else begin
                  phase_in = (req_data_byte == 8'd0) ? PH_TYPE : PH_SKIP;
               end
            end
            PH_KNOWN: begin
               value_in      = {value_ff[23:0], req_data_byte};
               bytes_left_in = bytes_dec;
               // Commit on the last value byte, routed by the current codes
               if (bytes_dec == 8'd0) begin
                  phase_in = PH_TYPE;
                  if (entry_type_ff == dev_code_ff) begin
                     held_dev_in = {value_ff[23:0], req_data_byte};
                  end else if (entry_type_ff == temp_code_ff) begin
                     held_temp_in = {value_ff[23:0], req_data_byte};
                  end else if (entry_type_ff == hum_code_ff) begin
                     held_hum_in = {value_ff[23:0], req_data_byte};
                  end
               end
            end
            PH_SKIP: begin
               bytes_left_in = bytes_dec;
               if (bytes_dec == 8'd0) begin
                  phase_in = PH_TYPE;
               end
            end
            default: begin
               entry_type_in = req_data_byte;
               phase_in      = PH_LEN;
            end
         endcase
      end
   end

   // Hold control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_code_ff   <= DEVICE_CODE_RESET;
         temp_code_ff  <= TEMPERATURE_CODE_RESET;
         hum_code_ff   <= HUMIDITY_CODE_RESET;
         phase_ff      <= PH_TYPE;
         entry_type_ff <= '0;
         bytes_left_ff <= '0;
         value_ff      <= '0;
         held_dev_ff   <= '0;
         held_temp_ff  <= '0;
         held_hum_ff   <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dev_code_ff   <= dev_code_in;
         temp_code_ff  <= temp_code_in;
         hum_code_ff   <= hum_code_in;
         phase_ff      <= phase_in;
         entry_type_ff <= entry_type_in;
         bytes_left_ff <= bytes_left_in;
         value_ff      <= value_in;
         held_dev_ff   <= held_dev_in;
         held_temp_ff  <= held_temp_in;
         held_hum_ff   <= held_hum_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_dev_ff    <= rsp_dev_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_hum_ff    <= rsp_hum_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_unit_ident       = rsp_dev_ff;
   assign rsp_temperature_bits = rsp_temp_ff;
   assign rsp_humidity_bits    = rsp_hum_ff;

   // An end transaction leaves a clean parser behind
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_END) |=> (phase_ff == PH_TYPE && !error_ff))
      else $error("parser not cleared after end transaction");

   // A result appears only after an accepted end transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_cmd == CMD_END))
      else $error("result without end transaction");

   // A known entry always has between one and four value bytes pending
   a_known_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_KNOWN) |-> (bytes_left_ff != 8'd0 && bytes_left_ff <= KNOWN_LENGTH))
      else $error("known entry byte count out of range");

   // A skipped entry never sits at zero bytes left
   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (bytes_left_ff != 8'd0))
      else $error("skip phase with no bytes left");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import tlvtp_pkg::*;

   // Index with no register behind it; writes there must be ignored
   localparam logic [1:0] CSR_NONE = 2'd3;

   localparam int ITEM_TARGET     = 1550;
   localparam int CODE_SETTINGS   = 8;
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT     = 40;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 10;
   localparam int NUM_DIRECTED    = 22;

   typedef struct packed {
      logic        status;
      logic [31:0] unit_ident;
      logic [31:0] temperature_bits;
      logic [31:0] humidity_bits;
   } report_type;

   // One directed transaction; summary is used only where fixed is set
   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       fixed;
      report_type summary;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // empty buffer right after reset
      '{CMD_END,  8'h00, 1'b1, '{1'b0, 32'h0, 32'h0, 32'h0}},
      // device id entry
      '{CMD_BYTE, 8'h01, 1'b0, '0},
      '{CMD_BYTE, 8'h04, 1'b0, '0},
      '{CMD_BYTE, 8'hDE, 1'b0, '0},
      '{CMD_BYTE, 8'hAD, 1'b0, '0},
      '{CMD_BYTE, 8'hBE, 1'b0, '0},
      '{CMD_BYTE, 8'hEF, 1'b0, '0},
      // humidity entry, all ones
      '{CMD_BYTE, 8'h03, 1'b0, '0},
      '{CMD_BYTE, 8'h04, 1'b0, '0},
      '{CMD_BYTE, 8'hFF, 1'b0, '0},
      '{CMD_BYTE, 8'hFF, 1'b0, '0},
      '{CMD_BYTE, 8'hFF, 1'b0, '0},
      '{CMD_BYTE, 8'hFF, 1'b0, '0},
      // unknown type with zero length
      '{CMD_BYTE, 8'hFF, 1'b0, '0},
      '{CMD_BYTE, 8'h00, 1'b0, '0},
      '{CMD_END,  8'hA5, 1'b1, '{1'b0, 32'hDEADBEEF, 32'h0, 32'hFFFFFFFF}},
      // known type with wrong length, then a byte that must be ignored
      '{CMD_BYTE, 8'h02, 1'b0, '0},
      '{CMD_BYTE, 8'h05, 1'b0, '0},
      '{CMD_BYTE, 8'h01, 1'b0, '0},
      '{CMD_END,  8'h00, 1'b1, '{1'b1, 32'h0, 32'h0, 32'h0}},
      // buffer ends after a type byte
      '{CMD_BYTE, 8'h02, 1'b0, '0},
      '{CMD_END,  8'hFF, 1'b1, '{1'b1, 32'h0, 32'h0, 32'h0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [31:0] rsp_unit_ident;
   logic [31:0] rsp_temperature_bits;
   logic [31:0] rsp_humidity_bits;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_DEVICE_CODE;
   logic [7:0]  csr_write_data = 8'h00;

   // Parser copy: type codes and per-buffer state
   logic [7:0]  code_dev, code_temp, code_hum;
   phase_type   cur_phase;
   logic [7:0]  cur_type;
   logic [7:0]  bytes_due;
   logic [31:0] word_acc;
   logic [31:0] dev_word, temp_word, hum_word;
   logic        sticky_err;

   report_type  pending_reports[$];

   int items_sent;
   int buffers_sent;
   int settings_used;
   int reports_checked;
   int reports_flagged;
   int mismatches;
   int stuck_cycles;
   bit burst_mode;
   bit held_off;

   tlv_telemetry_parser i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_unit_ident       (rsp_unit_ident),
      .rsp_temperature_bits (rsp_temperature_bits),
      .rsp_humidity_bits    (rsp_humidity_bits),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic bit code_known(logic [7:0] t);
      return t == code_dev || t == code_temp || t == code_hum;
   endfunction

   function automatic void clear_buffer();
      cur_phase  = PH_TYPE;
      cur_type   = '0;
      bytes_due  = '0;
      word_acc   = '0;
      dev_word   = '0;
      temp_word  = '0;
      hum_word   = '0;
      sticky_err = 1'b0;
   endfunction

   // Advance the parser copy by one accepted transaction; queue the report on end
   function automatic void track_parser(logic cmd, logic [7:0] b);
      if (cmd == CMD_BYTE) begin
         if (!sticky_err) begin
            case (cur_phase)
               PH_LEN: begin
                  bytes_due = b;
                  word_acc  = '0;
                  if (code_known(cur_type)) begin
                     if (b != KNOWN_LENGTH)
                        sticky_err = 1'b1;
                     else
                        cur_phase = PH_KNOWN;
                  end else begin
                     cur_phase = (b == 8'd0) ? PH_TYPE : PH_SKIP;
                  end
               end
               PH_KNOWN: begin
                  word_acc  = {word_acc[23:0], b};
                  bytes_due = bytes_due - 8'd1;
                  if (bytes_due == 8'd0) begin
                     // destination follows the codes in force at the last byte
                     if (cur_type == code_dev)
                        dev_word = word_acc;
                     else if (cur_type == code_temp)
                        temp_word = word_acc;
                     else if (cur_type == code_hum)
                        hum_word = word_acc;
                     cur_phase = PH_TYPE;
                  end
               end
               PH_SKIP: begin
                  bytes_due = bytes_due - 8'd1;
                  if (bytes_due == 8'd0)
                     cur_phase = PH_TYPE;
               end
               default: begin
                  cur_type  = b;
                  cur_phase = PH_LEN;
               end
            endcase
         end
      end else begin
         // an end in the middle of an entry counts as truncation
         if (cur_phase != PH_TYPE)
            sticky_err = 1'b1;
         pending_reports.push_back('{sticky_err, dev_word, temp_word, hum_word});
         clear_buffer();
      end
   endfunction

   function automatic void flag_error(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
   endfunction

   // Compare one accepted report against the oldest expectation
   function automatic void check_report();
      report_type want;
      report_type got;
      got = '{rsp_status, rsp_unit_ident, rsp_temperature_bits, rsp_humidity_bits};
      reports_checked++;
      if (got.status)
         reports_flagged++;
      if (pending_reports.size() == 0) begin
         flag_error("unexpected report, status", 32'h0, 32'(got.status));
         return;
      end
      want = pending_reports.pop_front();
      if (got.status != want.status)
         flag_error("status", 32'(want.status), 32'(got.status));
      if (got.unit_ident != want.unit_ident)
         flag_error("unit_ident", want.unit_ident, got.unit_ident);
      if (got.temperature_bits != want.temperature_bits)
         flag_error("temperature_bits", want.temperature_bits, got.temperature_bits);
      if (got.humidity_bits != want.humidity_bits)
         flag_error("humidity_bits", want.humidity_bits, got.humidity_bits);
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 2))
         0:       return code_dev;
         1:       return code_temp;
         default: return code_hum;
      endcase
   endfunction

   function automatic logic [7:0] unknown_code();
      logic [7:0] t;
      do
         t = 8'($urandom_range(0, 255));
      while (code_known(t));
      return t;
   endfunction

   // Value byte leaning toward the extremes
   function automatic logic [7:0] value_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one transaction after a random gap and hold it until accepted
   task automatic send_item(logic cmd, logic [7:0] b);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      track_parser(cmd, b);
   endtask

   // Drop valid and wait until every report is in and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write
   task automatic put_reg(logic [1:0] idx, logic [7:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= v;
      @(posedge clock);
      case (idx)
         CSR_DEVICE_CODE:      code_dev  = v;
         CSR_TEMPERATURE_CODE: code_temp = v;
         CSR_HUMIDITY_CODE:    code_hum  = v;
         default: ;
      endcase
   endtask

   task automatic write_codes(logic [7:0] dev, logic [7:0] temp, logic [7:0] hum);
      wait_idle();
      put_reg(CSR_DEVICE_CODE, dev);
      put_reg(CSR_TEMPERATURE_CODE, temp);
      put_reg(CSR_HUMIDITY_CODE, hum);
      put_reg(CSR_NONE, 8'($urandom_range(0, 255)));
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // One random buffer: mostly well-formed entries, some unknown, malformed or noise
   task automatic send_buffer();
      int entries;
      int kind;
      int len;
      int cut;
      entries = $urandom_range(0, 5);
      for (int e = 0; e < entries; e++) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_item(CMD_BYTE, pick_code());
            send_item(CMD_BYTE, KNOWN_LENGTH);
            repeat (4) send_item(CMD_BYTE, value_byte());
         end else if (kind < 85) begin
            len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 6);
            send_item(CMD_BYTE, unknown_code());
            send_item(CMD_BYTE, 8'(len));
            repeat (len) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         end else if (kind < 93) begin
            do
               len = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255);
            while (len == 4);
            send_item(CMD_BYTE, pick_code());
            send_item(CMD_BYTE, 8'(len));
            repeat ($urandom_range(0, 5)) send_item(CMD_BYTE, value_byte());
         end else begin
            repeat ($urandom_range(1, 6)) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
         end
      end
      // cut the buffer short inside a header or value now and then
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(0, 4);
         send_item(CMD_BYTE, pick_code());
         if (cut > 0)
            send_item(CMD_BYTE, KNOWN_LENGTH);
         repeat (cut - 1) send_item(CMD_BYTE, value_byte());
      end
      send_item(CMD_END, 8'($urandom_range(0, 255)));
      buffers_sent++;
   endtask

   // Stimulus
   initial begin : stimulus
      int phase_stop;
      code_dev  = DEVICE_CODE_RESET;
      code_temp = TEMPERATURE_CODE_RESET;
      code_hum  = HUMIDITY_CODE_RESET;
      clear_buffer();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows with reset codes
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].data);
         if (DIRECTED_ROWS[i].fixed) begin
            void'(pending_reports.pop_back());
            pending_reports.push_back(DIRECTED_ROWS[i].summary);
         end
      end

      // move the device code away in the middle of a device entry: word is dropped
      send_item(CMD_BYTE, DEVICE_CODE_RESET);
      send_item(CMD_BYTE, KNOWN_LENGTH);
      send_item(CMD_BYTE, 8'h11);
      send_item(CMD_BYTE, 8'h22);
      wait_idle();
      put_reg(CSR_DEVICE_CODE, 8'h07);
      csr_write_enable <= 1'b0;
      send_item(CMD_BYTE, 8'h33);
      send_item(CMD_BYTE, 8'h44);
      send_item(CMD_END, 8'h00);

      // random buffers under a series of code settings
      for (int p = 0; p < CODE_SETTINGS; p++) begin
         case (p)
            0: write_codes(DEVICE_CODE_RESET, TEMPERATURE_CODE_RESET, HUMIDITY_CODE_RESET);
            1: write_codes(8'h00, 8'h00, 8'h00);
            2: write_codes(8'hFF, 8'hFF, 8'hFF);
            3: write_codes(8'h00, 8'h80, 8'hFF);
            4: write_codes(8'hFF, 8'h00, 8'h07);
            5: write_codes(8'h10, 8'h10, 8'h20);
            default: write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
         endcase
         phase_stop = items_sent + (ITEM_TARGET - items_sent) / (CODE_SETTINGS - p);
         while (items_sent < phase_stop) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            send_buffer();
         end
      end

      burst_mode = 1'b0;
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d transactions in %0d random buffers over %0d code settings.",
               items_sent, buffers_sent, settings_used);
      $display("Checked %0d reports, %0d of them flagged malformed; %0d mismatches.",
               reports_checked, reports_flagged, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Report side: random stalls, quiet stretches and one long hold-off
   initial begin : report_sink
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && reports_checked == HOLD_OFF_AT) begin
            held_off = 1'b1;
            stall    = HOLD_OFF_CYCLES;
         end else if ((reports_checked / 16) % 3 == 0) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 8);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_report();
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles == IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d reports outstanding",
                  IDLE_LIMIT, pending_reports.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

// ----- tlv_telemetry_parser.f -----
design/tlvtp_pkg.sv
design/tlv_telemetry_parser.sv
dv/tb.sv
